@@ rtl/barph_pkg.sv @@
// Package for the band analyser readout with peak hold.
// Holds field widths, register codes, defaults and the microcode table.
// Depends on nothing; every other file of the block imports it.
package barph_pkg;

   localparam int unsigned BANDS_DEF  = 7;
   localparam int unsigned WINDOW_DEF = 8;

   localparam int unsigned SAMPLE_W   = 16;
   localparam int unsigned CNT_W      = 16;
   localparam int unsigned BAND_OUT_W = 3;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_GAP    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE = 1'd1;

   localparam logic [CNT_W-1:0] GAP_RESET    = 16'd4320;
   localparam logic [CNT_W-1:0] SETTLE_RESET = 16'd1920;

   // Microcode step addresses.
   localparam int unsigned UPC_W = 3;
   localparam logic [UPC_W-1:0] U_FETCH = 3'd0;
   localparam logic [UPC_W-1:0] U_CTRL  = 3'd1;
   localparam logic [UPC_W-1:0] U_WRITE = 3'd2;
   localparam logic [UPC_W-1:0] U_SCAN  = 3'd3;
   localparam logic [UPC_W-1:0] U_LAST  = 3'd4;
   localparam logic [UPC_W-1:0] U_EMIT  = 3'd5;

   // Sequencing conditions.
   localparam logic [1:0] JC_NEXT     = 2'd0;
   localparam logic [1:0] JC_GOTO     = 2'd1;
   localparam logic [1:0] JC_DISPATCH = 2'd2;
   localparam logic [1:0] JC_LOOP     = 2'd3;

   typedef struct packed {
      logic             ready;   // take a word from the request channel
      logic             wr;      // write the sample into its ring
      logic             clr;     // clear the running maximum and scan index
      logic             rd;      // read one ring entry, advance the index
      logic             cmp;     // fold the last read entry into the maximum
      logic             emit;    // update the readout state, load the result
      logic [1:0]       cond;
      logic [UPC_W-1:0] target;
   } ucode_type;

   function automatic ucode_type ucode_rom(input logic [UPC_W-1:0] upc);
      ucode_type cw;
      cw = '0;
      case (upc)
         U_FETCH: begin
            cw.ready = 1'b1;
            cw.cond  = JC_DISPATCH;
         end
         U_CTRL: begin
            cw.emit   = 1'b1;
            cw.cond   = JC_GOTO;
            cw.target = U_FETCH;
         end
         U_WRITE: begin
            cw.wr   = 1'b1;
            cw.clr  = 1'b1;
            cw.cond = JC_NEXT;
         end
         U_SCAN: begin
            cw.rd     = 1'b1;
            cw.cmp    = 1'b1;
            cw.cond   = JC_LOOP;
            cw.target = U_SCAN;
         end
         U_LAST: begin
            cw.cmp  = 1'b1;
            cw.cond = JC_NEXT;
         end
         U_EMIT: begin
            cw.emit   = 1'b1;
            cw.cond   = JC_GOTO;
            cw.target = U_FETCH;
         end
         default: begin
            cw.cond   = JC_GOTO;
            cw.target = U_FETCH;
         end
      endcase
      return cw;
   endfunction

endpackage

@@ rtl/barph_ifs.sv @@
// Valid/ready channel interfaces of the band analyser readout.
// The request channel carries one input word, the response channel one result word.
// Depends on barph_pkg for the field widths.
interface barph_req_if;
   import barph_pkg::*;

   logic                valid;
   logic                ready;
   logic                action;
   logic [SAMPLE_W-1:0] adc_sample;

   modport source (output valid, action, adc_sample, input ready);
   modport sink   (input valid, action, adc_sample, output ready);
endinterface

interface barph_rsp_if;
   import barph_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  reset_pulse;
   logic                  strobe_level;
   logic                  adc_start;
   logic                  peak_valid;
   logic [BAND_OUT_W-1:0] band;
   logic [SAMPLE_W-1:0]   peak;

   modport source (output valid, reset_pulse, strobe_level, adc_start, peak_valid, band, peak,
                   input ready);
   modport sink   (input valid, reset_pulse, strobe_level, adc_start, peak_valid, band, peak,
                   output ready);
endinterface

@@ rtl/band_analyzer_readout_peak_hold.sv @@
// Readout controller with peak hold: a tick word is accepted, then the result is loaded
// into the output register; a sample word in the await phase first runs the scan of the
// band's ring through the single read port of the sample memory, one entry a cycle.
// A new word is accepted only after the previous one has loaded its result.
// Synchronous active-high reset clears the sequencer, the readout state, the ring
// pointers and fill flags; no clearing pass, as entries not yet written are masked.
module band_analyzer_readout_peak_hold #(
   parameter int unsigned BANDS  = barph_pkg::BANDS_DEF,
   parameter int unsigned WINDOW = barph_pkg::WINDOW_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   barph_req_if.sink                       req_ch,
   barph_rsp_if.source                     rsp_ch,
   input  logic                            csr_we,
   input  logic [barph_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [barph_pkg::CSR_DATA_W-1:0] csr_data
);
   import barph_pkg::*;

   localparam int unsigned BAND_W = (BANDS > 1) ? $clog2(BANDS) : 1;
   localparam int unsigned PTR_W  = $clog2(WINDOW);
   localparam int unsigned DEPTH  = BANDS * WINDOW;
   localparam int unsigned ADDR_W = $clog2(DEPTH);
   localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(WINDOW - 1);
   localparam logic [ADDR_W-1:0] ROW_LEN  = ADDR_W'(WINDOW);
   localparam logic [BAND_W:0]   BAND_CNT = (BAND_W + 1)'(BANDS);

   // Readout phases, one per step of the analyser's strobe cycle.
   localparam logic [2:0] PH_START        = 3'd0;
   localparam logic [2:0] PH_RESET_GAP    = 3'd1;
   localparam logic [2:0] PH_SETTLE       = 3'd2;
   localparam logic [2:0] PH_AWAIT_SAMPLE = 3'd3;
   localparam logic [2:0] PH_BAND_GAP     = 3'd4;

   // Sequencer.
   logic [UPC_W-1:0] upc_ff, upc_in;
   ucode_type        cw;
   logic             accept;
   logic             emit_go;

   // Latched request word.
   logic                action_ff;
   logic [SAMPLE_W-1:0] sample_ff;

   // Configuration registers.
   logic [CNT_W-1:0] gap_ff;
   logic [CNT_W-1:0] settle_ff;

   // Readout state.
   logic [2:0]        phase_ff, phase_in;
   logic [BAND_W-1:0] band_ff, band_in;
   logic [CNT_W-1:0]  wait_ff, wait_in;
   logic [CNT_W-1:0]  wait_dec;
   logic              strobe_ff, strobe_in;
   logic [BAND_W-1:0] band_sel;
   logic              last_band;

   // Rings: write pointer and a flag that is set once the ring has wrapped.
   logic [PTR_W-1:0]    ring_ptr_ff [BANDS];
   logic                ring_full_ff [BANDS];
   logic [SAMPLE_W-1:0] sample_mem_ff [DEPTH];
   logic [ADDR_W-1:0]   row_base;
   logic [ADDR_W-1:0]   wr_addr;
   logic [ADDR_W-1:0]   rd_addr;

   // Scan datapath.
   logic [PTR_W-1:0]    idx_ff;
   logic [SAMPLE_W-1:0] rd_data_ff;
   logic                rd_ok_ff;
   logic                rd_live_ff;
   logic [SAMPLE_W-1:0] max_ff;

   // Result word under construction and the output register.
   logic                  o_reset_pulse;
   logic                  o_adc_start;
   logic                  o_peak_valid;
   logic [BAND_OUT_W-1:0] o_band;
   logic [SAMPLE_W-1:0]   o_peak;
   logic                  out_full_ff;
   logic                  out_reset_pulse_ff;
   logic                  out_strobe_ff;
   logic                  out_adc_start_ff;
   logic                  out_peak_valid_ff;
   logic [BAND_OUT_W-1:0] out_band_ff;
   logic [SAMPLE_W-1:0]   out_peak_ff;

   assign cw      = ucode_rom(upc_ff);
   assign accept  = cw.ready && req_ch.valid;
   assign emit_go = cw.emit && !(out_full_ff && !rsp_ch.ready);

   assign req_ch.ready = cw.ready;

   // A band number outside the configured range is read as band zero.
   assign band_sel  = ({1'b0, band_ff} < BAND_CNT) ? band_ff : '0;
   assign last_band = ((BAND_W + 1)'(band_sel) + 1'b1) >= BAND_CNT;
   assign wait_dec  = wait_ff - 1'b1;

   assign row_base = ADDR_W'(band_sel) * ROW_LEN;
   assign wr_addr  = row_base + ADDR_W'(ring_ptr_ff[band_sel]);
   assign rd_addr  = row_base + ADDR_W'(idx_ff);

   // Next micro-step. A sample in the await phase runs the ring program, every other
   // word goes straight to the control step. An emit step holds while the output
   // register is still occupied.
   always_comb begin
      upc_in = upc_ff;
      case (cw.cond)
         JC_NEXT: upc_in = upc_ff + 1'b1;
         JC_GOTO: upc_in = cw.target;
         JC_DISPATCH: begin
            if (accept) begin
               upc_in = (phase_ff == PH_AWAIT_SAMPLE && req_ch.action) ? U_WRITE : U_CTRL;
            end
         end
         JC_LOOP: upc_in = (idx_ff != PTR_LAST) ? cw.target : upc_ff + 1'b1;
         default: upc_in = U_FETCH;
      endcase
      if (cw.emit && !emit_go) begin
         upc_in = upc_ff;
      end
   end

   // Readout state update for one word, applied on the emit step. A wait loaded with
   // N ends on its (N+1)-th tick; ticks while a sample is awaited change nothing.
   always_comb begin
      phase_in      = phase_ff;
      band_in       = band_ff;
      wait_in       = wait_ff;
      strobe_in     = strobe_ff;
      o_reset_pulse = 1'b0;
      o_adc_start   = 1'b0;
      o_peak_valid  = 1'b0;
      o_peak        = '0;
      case (phase_ff)
         PH_START: begin
            o_reset_pulse = 1'b1;
            band_in       = '0;
            wait_in       = gap_ff;
            phase_in      = PH_RESET_GAP;
         end
         PH_RESET_GAP: begin
            if (!action_ff) begin
               if (wait_ff == '0) begin
                  strobe_in = 1'b0;
                  wait_in   = settle_ff;
                  phase_in  = PH_SETTLE;
               end else begin
                  wait_in = wait_dec;
               end
            end
         end
         PH_SETTLE: begin
            if (!action_ff) begin
               if (wait_ff == '0) begin
                  o_adc_start = 1'b1;
                  phase_in    = PH_AWAIT_SAMPLE;
               end else begin
                  wait_in = wait_dec;
               end
            end
         end
         PH_AWAIT_SAMPLE: begin
            if (action_ff) begin
               o_peak_valid = 1'b1;
               o_peak       = max_ff;
               strobe_in    = 1'b1;
               wait_in      = gap_ff;
               if (last_band) begin
                  // The last band closes the cycle: the next reset pulse goes out now.
                  o_reset_pulse = 1'b1;
                  band_in       = '0;
                  phase_in      = PH_RESET_GAP;
               end else begin
                  phase_in = PH_BAND_GAP;
               end
            end
         end
         PH_BAND_GAP: begin
            if (!action_ff) begin
               if (wait_ff == '0) begin
                  band_in   = band_sel + 1'b1;
                  strobe_in = 1'b0;
                  wait_in   = settle_ff;
                  phase_in  = PH_SETTLE;
               end else begin
                  wait_in = wait_dec;
               end
            end
         end
         default: phase_in = PH_START;
      endcase
      o_band = o_peak_valid ? BAND_OUT_W'(band_sel) : BAND_OUT_W'(band_in);
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= U_FETCH;
         gap_ff       <= GAP_RESET;
         settle_ff    <= SETTLE_RESET;
         phase_ff     <= PH_START;
         band_ff      <= '0;
         wait_ff      <= '0;
         strobe_ff    <= 1'b1;
         ring_ptr_ff  <= '{default: '0};
         ring_full_ff <= '{default: 1'b0};
         rd_live_ff   <= 1'b0;
         out_full_ff  <= 1'b0;
      end else begin
         upc_ff     <= upc_in;
         rd_live_ff <= cw.rd;
         if (csr_we) begin
            case (csr_index)
               CSR_GAP:    gap_ff    <= csr_data;
               CSR_SETTLE: settle_ff <= csr_data;
               default: ;
            endcase
         end
         if (cw.wr) begin
            if (ring_ptr_ff[band_sel] == PTR_LAST) begin
               ring_ptr_ff[band_sel]  <= '0;
               ring_full_ff[band_sel] <= 1'b1;
            end else begin
               ring_ptr_ff[band_sel] <= ring_ptr_ff[band_sel] + 1'b1;
            end
         end
         if (emit_go) begin
            phase_ff    <= phase_in;
            band_ff     <= band_in;
            wait_ff     <= wait_in;
            strobe_ff   <= strobe_in;
            out_full_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_full_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_ch.action;
         sample_ff <= req_ch.adc_sample;
      end
      if (cw.clr) begin
         idx_ff <= '0;
         max_ff <= '0;
      end else begin
         if (cw.rd) begin
            idx_ff <= idx_ff + 1'b1;
         end
         // Entries not written since reset are masked, so they cannot raise the maximum.
         if (cw.cmp && rd_live_ff && rd_ok_ff && (rd_data_ff > max_ff)) begin
            max_ff <= rd_data_ff;
         end
      end
      if (cw.rd) begin
         rd_ok_ff <= ring_full_ff[band_sel] || (idx_ff < ring_ptr_ff[band_sel]);
      end
      if (emit_go) begin
         out_reset_pulse_ff <= o_reset_pulse;
         out_strobe_ff      <= strobe_in;
         out_adc_start_ff   <= o_adc_start;
         out_peak_valid_ff  <= o_peak_valid;
         out_band_ff        <= o_band;
         out_peak_ff        <= o_peak;
      end
   end

   // Sample store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cw.wr) begin
         sample_mem_ff[wr_addr] <= sample_ff;
      end
      if (cw.rd) begin
         rd_data_ff <= sample_mem_ff[rd_addr];
      end
   end

   assign rsp_ch.valid        = out_full_ff;
   assign rsp_ch.reset_pulse  = out_reset_pulse_ff;
   assign rsp_ch.strobe_level = out_strobe_ff;
   assign rsp_ch.adc_start    = out_adc_start_ff;
   assign rsp_ch.peak_valid   = out_peak_valid_ff;
   assign rsp_ch.band         = out_band_ff;
   assign rsp_ch.peak         = out_peak_ff;

endmodule

@@ rtl/barph_checker.sv @@
// Port-level checks on the response channel of the band analyser readout.
// Depends on barph_pkg; bound to band_analyzer_readout_peak_hold below.
module barph_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic                             rsp_reset_pulse,
   input logic                             rsp_strobe_level,
   input logic                             rsp_adc_start,
   input logic                             rsp_peak_valid,
   input logic [barph_pkg::BAND_OUT_W-1:0] rsp_band,
   input logic [barph_pkg::SAMPLE_W-1:0]   rsp_peak
);
   import barph_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_reset_pulse, rsp_strobe_level,
         rsp_adc_start, rsp_peak_valid, rsp_band, rsp_peak}))
      else $error("response word changed while stalled");

   a_peak_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_peak_valid |-> rsp_strobe_level)
      else $error("peak reported while strobe is low");

   a_start_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_adc_start |-> !rsp_peak_valid && !rsp_reset_pulse && !rsp_strobe_level)
      else $error("conversion start mixed with another event");

   a_peak_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_peak_valid |-> rsp_peak == '0)
      else $error("peak field set without a new result");

endmodule

bind band_analyzer_readout_peak_hold barph_checker u_barph_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_reset_pulse  (rsp_ch.reset_pulse),
   .rsp_strobe_level (rsp_ch.strobe_level),
   .rsp_adc_start    (rsp_ch.adc_start),
   .rsp_peak_valid   (rsp_ch.peak_valid),
   .rsp_band         (rsp_ch.band),
   .rsp_peak         (rsp_ch.peak)
);
